// ===== hdl/rsmp_pkg.sv =====
// Shared types and constants for the polyphase resampler.
package rsmp_pkg;

	// Fixed field and register widths
	localparam int REQ_W     = 2;
	localparam int PSTEP_W   = 23;
	localparam int NPH_W     = 9;
	localparam int TCNT_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CPH_W     = 8;
	localparam int CTAP_W    = 6;
	localparam int PUSED_W   = 8;

	// Phase accumulator: 16 fraction bits, one guard bit above the register width
	localparam int            PHASE_FRAC = 16;
	localparam int            PA_W       = PSTEP_W + 1;
	localparam logic [PA_W-1:0] PHASE_ONE  = PA_W'(1) << PHASE_FRAC;
	localparam logic [PA_W-1:0] PHASE_HALF = PA_W'(1) << (PHASE_FRAC - 1);

	localparam int OUT_CAP  = 64;
	localparam int CNT_W    = $clog2(OUT_CAP + 1);
	localparam int MIN_TAPS = 8;

	localparam logic [PSTEP_W-1:0] PSTEP_RST = PSTEP_W'(65536);
	localparam logic [NPH_W-1:0]   NPH_RST   = NPH_W'(32);
	localparam logic [TCNT_W-1:0]  TCNT_RST  = TCNT_W'(64);

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_COEF   = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_NUM_PHASES = 2'd1,
		REG_TAP_COUNT  = 2'd2
	} cfg_reg_t;

	// Control that travels with each dot-product term
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} term_ctl_t;

endpackage

// ===== hdl/polyphase_resampler_top.sv =====
// Polyphase resampler: sequencer around one shared multiply-accumulate.
// A sample first folds the write position into the ring, then each output passes
// through the phase row, the taps through the MAC, the MAC pipeline and the emit
// (held by out_stall); up to 64 outputs per sample. Coefficient and clear
// transactions leave the sequencer idle. Asynchronous reset clears ring valid bits,
// position, phase and config to defaults; the coefficient table is not cleared.
module polyphase_resampler_top
	import rsmp_pkg::*;
#(
	parameter int MAX_TAPS    = 64,
	parameter int MAX_PHASES  = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [PSTEP_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic [CPH_W-1:0]       coef_phase,
	input  logic [CTAP_W-1:0]      coef_tap,
	input  logic [COEF_BITS-1:0]   coef_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic                   last,
	output logic [PUSED_W-1:0]     phase_used
);

	localparam int RI_W     = $clog2(MAX_TAPS);
	localparam int TC_W     = $clog2(MAX_TAPS + 1);
	localparam int PN_W     = $clog2(MAX_PHASES + 1);
	localparam int ROW_W    = $clog2(MAX_PHASES);
	localparam int CA_DEPTH = MAX_PHASES * MAX_TAPS;
	localparam int CA_W     = $clog2(CA_DEPTH);
	localparam int RP_W     = PHASE_FRAC + PN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_ROW,
		ST_ROW2,
		ST_MAC,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// Configuration
	logic [PSTEP_W-1:0] phase_step_q;
	logic [NPH_W-1:0]   num_phases_q;
	logic [TCNT_W-1:0]  tap_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PSTEP_RST;
			num_phases_q <= NPH_RST;
			tap_count_q  <= TCNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_NUM_PHASES: num_phases_q <= cfg_data[NPH_W-1:0];
				REG_TAP_COUNT:  tap_count_q  <= cfg_data[TCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped taps and phases in use
	logic [TC_W-1:0] taps_c;
	logic [PN_W-1:0] phases_c;

	always_comb begin
		if (tap_count_q < TCNT_W'(MIN_TAPS)) begin
			taps_c = TC_W'(MIN_TAPS);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_c = TC_W'(MAX_TAPS);
		end else begin
			taps_c = TC_W'(tap_count_q);
		end
		if (32'(num_phases_q) > MAX_PHASES) begin
			phases_c = PN_W'(MAX_PHASES);
		end else begin
			phases_c = PN_W'(num_phases_q);
		end
	end

	// Sequencer state
	state_t                  state_q;
	logic [SAMPLE_BITS-1:0]  sample_q;
	logic [RI_W-1:0]         wp_q;
	logic [PA_W-1:0]         phase_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [RP_W-1:0]         rowp_q;
	logic [ROW_W-1:0]        row_q;
	logic [RI_W-1:0]         n_q;
	logic [RI_W-1:0]         slot_q;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  sample_out_q;
	logic                    last_q;
	logic [ROW_W-1:0]        phase_used_q;

	logic                    in_acc;
	logic                    mac_done;
	logic [SAMPLE_BITS-1:0]  mac_result;
	logic [PA_W-1:0]         phase_nxt;
	logic [RP_W:0]           row_sum;
	logic [PN_W:0]           row_raw;
	logic                    issue_last;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign phase_nxt  = phase_q + PA_W'(phase_step_q);
	assign row_sum    = (RP_W + 1)'(rowp_q) + (RP_W + 1)'(PHASE_HALF);
	assign row_raw    = row_sum[RP_W:PHASE_FRAC];
	assign issue_last = (TC_W'(n_q) + TC_W'(1)) == taps_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sample_q     <= '0;
			wp_q         <= '0;
			phase_q      <= '0;
			cnt_q        <= '0;
			rowp_q       <= '0;
			row_q        <= '0;
			n_q          <= '0;
			slot_q       <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			last_q       <= 1'b0;
			phase_used_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req_t'(req_type))
							REQ_SAMPLE: begin
								sample_q <= sample_in;
								state_q  <= ST_REDUCE;
							end
							REQ_CLEAR: begin
								wp_q    <= '0;
								phase_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_REDUCE: begin
					// fold a stale position after tap_count shrank
					if (TC_W'(wp_q) >= taps_c) begin
						wp_q <= RI_W'(TC_W'(wp_q) - taps_c);
					end else begin
						if (issue_last_wp(wp_q, taps_c)) begin
							wp_q   <= '0;
							slot_q <= '0;
						end else begin
							wp_q   <= wp_q + RI_W'(1);
							slot_q <= wp_q + RI_W'(1);
						end
						cnt_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (phase_q < PHASE_ONE && 32'(cnt_q) < OUT_CAP) begin
						state_q <= ST_ROW;
					end else begin
						if (phase_q >= PHASE_ONE) begin
							phase_q <= {1'b0, phase_q[PA_W-2:0] - PHASE_ONE[PA_W-2:0]};
						end else begin
							phase_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ROW: begin
					rowp_q  <= RP_W'(phase_q[PHASE_FRAC-1:0]) * RP_W'(phases_c);
					state_q <= ST_ROW2;
				end
				ST_ROW2: begin
					// rounded row is at most the clamped phase count, which wraps to row 0
					if (row_raw >= (PN_W + 1)'(phases_c)) begin
						row_q <= '0;
					end else begin
						row_q <= ROW_W'(row_raw);
					end
					n_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					n_q <= n_q + RI_W'(1);
					if (slot_q == '0) begin
						slot_q <= RI_W'(taps_c - TC_W'(1));
					end else begin
						slot_q <= slot_q - RI_W'(1);
					end
					if (issue_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= mac_result;
						phase_used_q <= row_q;
						last_q       <= (phase_nxt >= PHASE_ONE) ||
							(32'(cnt_q) == OUT_CAP - 1);
						phase_q      <= phase_nxt;
						cnt_q        <= cnt_q + CNT_W'(1);
						// walk starts again at the write position, the slot after the newest sample
						slot_q       <= wp_q;
						state_q      <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	function automatic logic issue_last_wp(input logic [RI_W-1:0] pos,
		input logic [TC_W-1:0] taps);
		issue_last_wp = (TC_W'(pos) + TC_W'(1)) == taps;
	endfunction

	// Sample ring
	logic                          ring_we;
	logic                          ring_clr;
	logic signed [SAMPLE_BITS-1:0] ring_rdata;

	assign ring_we  = (state_q == ST_REDUCE) && (TC_W'(wp_q) < taps_c);
	assign ring_clr = in_acc && (req_t'(req_type) == REQ_CLEAR);

	rsmp_ring #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (ring_clr),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (sample_q),
		.raddr (slot_q),
		.rdata (ring_rdata)
	);

	// Coefficient table
	logic                 coef_we;
	logic [CA_W-1:0]      coef_waddr;
	logic [CA_W-1:0]      coef_raddr;
	logic [COEF_BITS-1:0] coef_rdata;

	assign coef_we    = in_acc && (req_t'(req_type) == REQ_COEF) &&
		(32'(coef_phase) < MAX_PHASES) && (32'(coef_tap) < MAX_TAPS);
	assign coef_waddr = CA_W'(coef_phase) * CA_W'(MAX_TAPS) + CA_W'(coef_tap);
	assign coef_raddr = CA_W'(row_q) * CA_W'(MAX_TAPS) + CA_W'(n_q);

	rsmp_coef_ram #(
		.DEPTH(CA_DEPTH),
		.DW   (COEF_BITS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_value),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	// Term control, aligned with the registered memory reads
	term_ctl_t iss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
		end else begin
			iss_s1.valid <= (state_q == ST_MAC);
			iss_s1.first <= (n_q == '0);
			iss_s1.last  <= issue_last;
		end
	end

	rsmp_mac #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (iss_s1),
		.sample(ring_rdata),
		.coef  ($signed(coef_rdata)),
		.done  (mac_done),
		.result(mac_result)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign last       = last_q;
	assign phase_used = PUSED_W'(phase_used_q);

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_WAIT)
		else $error("MAC finished outside of wait state");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= OUT_CAP)
		else $error("output count past cap");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> TC_W'(slot_q) < taps_c)
		else $error("ring slot outside taps in use");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && phases_c != '0) |-> PN_W'(row_q) < phases_c)
		else $error("phase row outside phases in use");
`endif

endmodule

// ===== hdl/rsmp_coef_ram.sv =====
// Coefficient table: one write port, one registered read port.
module rsmp_coef_ram
	import rsmp_pkg::*;
#(
	parameter int DEPTH = 16384,
	parameter int DW    = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/rsmp_ring.sv =====
// Sample ring memory with per-entry valid bits; an unwritten entry reads as zero.
module rsmp_ring
	import rsmp_pkg::*;
#(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          we,
	input  logic [$clog2(MAX_TAPS)-1:0]   waddr,
	input  logic [SAMPLE_BITS-1:0]        wdata,
	input  logic [$clog2(MAX_TAPS)-1:0]   raddr,
	output logic signed [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]    vld_q;
	logic [SAMPLE_BITS-1:0] data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_q <= mem[raddr];
	end

	assign rdata = rd_vld_q ? $signed(data_q) : '0;

endmodule

// ===== hdl/rsmp_mac.sv =====
// Shared multiply-accumulate with round-half-up and saturation of the sum.
module rsmp_mac
	import rsmp_pkg::*;
#(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  term_ctl_t                     ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [COEF_BITS-1:0]   coef,
	output logic                          done,
	output logic [SAMPLE_BITS-1:0]        result
);

	localparam int PW = SAMPLE_BITS + COEF_BITS;
	localparam int AW = PW + $clog2(MAX_TAPS);

	localparam logic signed [AW:0] RND    = (AW + 1)'(1) << (COEF_BITS - 2);
	localparam logic signed [AW:0] SAT_HI = {{(AW + 2 - SAMPLE_BITS){1'b0}},
		{(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [AW:0] SAT_LO = {{(AW + 2 - SAMPLE_BITS){1'b1}},
		{(SAMPLE_BITS - 1){1'b0}}};

	term_ctl_t             ctl_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [AW-1:0]  acc_q;
	logic                  done_q;
	logic signed [AW:0]    rnd;
	logic signed [AW:0]    shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= sample * coef;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= AW'(prod_s2);
			end else begin
				acc_q <= acc_q + AW'(prod_s2);
			end
		end
	end

	always_comb begin
		rnd = (AW + 1)'(acc_q) + RND;
		shr = rnd >>> (COEF_BITS - 1);
		if (shr > SAT_HI) begin
			result = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shr < SAT_LO) begin
			result = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			result = shr[SAMPLE_BITS-1:0];
		end
	end

	assign done = done_q;

endmodule
